FILE: hdl/bis_pkg.sv
`default_nettype none
package bis_pkg;
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 12;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  // coordinate width shared by both mappers
  localparam int CW = (XW > YW) ? XW : YW;
  localparam int HXW = XW - 1;
  localparam int HYW = YW - 1;
  localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int BAW = HXW + HYW;
  localparam int ONEW = FRAC_BITS + 1;

  localparam logic [2:0] REG_SRC_W = 3'd0;
  localparam logic [2:0] REG_SRC_H = 3'd1;
  localparam logic [2:0] REG_TGT_W = 3'd2;
  localparam logic [2:0] REG_TGT_H = 3'd3;
  localparam logic [2:0] REG_STEP  = 3'd4;

  typedef struct packed {
    logic [9:0]  src_w;
    logic [9:0]  src_h;
    logic [12:0] tgt_w;
    logic [12:0] tgt_h;
    logic [15:0] step;
  } cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  // per-axis neighbor info after mapping
  typedef struct packed {
    logic [XW-1:0]        lo;
    logic [XW-1:0]        hi;
    logic [FRAC_BITS-1:0] frac;
  } axis_x_t;

  typedef struct packed {
    logic [YW-1:0]        lo;
    logic [YW-1:0]        hi;
    logic [FRAC_BITS-1:0] frac;
  } axis_y_t;
endpackage
`default_nettype wire

FILE: hdl/bis_ram.sv
`default_nettype none
module bis_ram #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic [DW-1:0]      rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/bis_map.sv
`default_nettype none
// Coordinate mapping: stage 1 multiplies, stage 2 splits and clamps.
module bis_map import bis_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [11:0] coord,
  input  wire logic [15:0] step,
  input  wire logic [9:0]  size,
  input  wire logic [CW-1:0] max_last,
  output logic [CW-1:0]        lo,
  output logic [CW-1:0]        hi,
  output logic [FRAC_BITS-1:0] frac
);
  logic [27:0]   pos_r;
  logic [CW-1:0] last_r;
  logic [CW-1:0] last_c;
  logic [27-FRAC_BITS:0] ip;

  always_comb begin
    if (size == 10'd0) last_c = '0;
    else if ((13'(size) - 13'd1) > 13'(max_last)) last_c = max_last;
    else last_c = CW'(size - 10'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r  <= 28'(coord) * 28'(step);
      last_r <= last_c;
    end
  end

  assign ip = pos_r[27:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      frac <= pos_r[FRAC_BITS-1:0];
      if (ip >= (28-FRAC_BITS)'(last_r)) begin
        lo <= last_r;
        hi <= last_r;
      end else begin
        lo <= ip[CW-1:0];
        hi <= ip[CW-1:0] + CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/bis_blend.sv
`default_nettype none
// One channel: horizontal blend in stage A, vertical blend in stage B.
module bis_blend import bis_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [7:0]           p00,
  input  wire logic [7:0]           p01,
  input  wire logic [7:0]           p10,
  input  wire logic [7:0]           p11,
  input  wire logic [FRAC_BITS-1:0] fx,
  input  wire logic [FRAC_BITS-1:0] fy,
  output logic [7:0]                res
);
  localparam int HW = 8 + FRAC_BITS;
  logic [HW-1:0] top_r, bot_r;
  logic [FRAC_BITS-1:0] fy_r;
  logic [ONEW-1:0] wx0, wy0;
  logic [HW+FRAC_BITS:0] v;

  assign wx0 = (ONEW'(1) << FRAC_BITS) - ONEW'(fx);
  assign wy0 = (ONEW'(1) << FRAC_BITS) - ONEW'(fy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      top_r <= HW'((HW+1)'(p00) * (HW+1)'(wx0) + (HW+1)'(p01) * (HW+1)'(fx));
      bot_r <= HW'((HW+1)'(p10) * (HW+1)'(wx0) + (HW+1)'(p11) * (HW+1)'(fx));
      fy_r  <= fy;
    end
  end

  assign v = (HW+FRAC_BITS+1)'(top_r) * (HW+FRAC_BITS+1)'(wy0)
           + (HW+FRAC_BITS+1)'(bot_r) * (HW+FRAC_BITS+1)'(fy_r);

  always_ff @(posedge clk) begin
    if (en) res <= v[2*FRAC_BITS +: 8];
  end
endmodule
`default_nettype wire

FILE: hdl/bilinear_image_scaler_core.sv
`default_nettype none
// Channel   Handshake        Payload
// in_       valid / stall    action, column, row_index, red/green/blue_in
// out_      valid / stall    red/green/blue_out, out_of_range
// cfg_      valid / ready    index, data
// Six-stage pipeline, one transaction per cycle while the output is not stalled.
// Frame store is four banks split by column/row parity, so all four
// neighbors are read in the same cycle. Writes enter the same pipe and write at
// stage 1, so a read sees every earlier write. Reset clears valid bits and
// loads the default config; store contents are undefined until written.
// A stall freezes the whole pipe.
module bilinear_image_scaler_core import bis_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [11:0] in_column,
  input  wire logic [11:0] in_row_index,
  input  wire logic [7:0]  in_red_in,
  input  wire logic [7:0]  in_green_in,
  input  wire logic [7:0]  in_blue_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_out_of_range,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  cfg_t cfg_r;
  logic en;
  logic [5:0] rv_r;
  logic [4:0] oor_r;
  logic       wv_r;
  logic [XW-1:0] wx_r;
  logic [YW-1:0] wy_r;
  pix_t wpix_r;
  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [FRAC_BITS-1:0] fx, fy, fx_r, fy_r;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [3:0] sel_r;
  pix_t bank_q [4];
  pix_t n00, n01, n10, n11;
  logic [7:0] r_c, g_c, b_c;
  logic oor_c;

  assign en = !out_stall || !out_valid;
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w <= 10'd512;
      cfg_r.src_h <= 10'd512;
      cfg_r.tgt_w <= 13'd512;
      cfg_r.tgt_h <= 13'd512;
      cfg_r.step  <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_W: cfg_r.src_w <= cfg_data[9:0];
        REG_SRC_H: cfg_r.src_h <= cfg_data[9:0];
        REG_TGT_W: cfg_r.tgt_w <= cfg_data[12:0];
        REG_TGT_H: cfg_r.tgt_h <= cfg_data[12:0];
        REG_STEP:  cfg_r.step  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign oor_c = (13'(in_column) >= cfg_r.tgt_w) || (13'(in_row_index) >= cfg_r.tgt_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
      wv_r <= 1'b0;
    end else if (en) begin
      rv_r <= {rv_r[4:0], in_valid && in_action};
      wv_r <= in_valid && !in_action && (in_column < 12'(MAX_WIDTH))
              && (in_row_index < 12'(MAX_HEIGHT));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r  <= {oor_r[3:0], oor_c};
      wx_r   <= in_column[XW-1:0];
      wy_r   <= in_row_index[YW-1:0];
      wpix_r <= '{r: in_red_in, g: in_green_in, b: in_blue_in};
    end
  end

  // stages 1-2
  logic [CW-1:0] xlo_w, xhi_w, ylo_w, yhi_w;
  bis_map u_mapx (.clk, .en, .coord(in_column), .step(cfg_r.step),
    .size(cfg_r.src_w), .max_last(CW'(MAX_WIDTH - 1)), .lo(xlo_w), .hi(xhi_w),
    .frac(fx));
  bis_map u_mapy (.clk, .en, .coord(in_row_index), .step(cfg_r.step),
    .size(cfg_r.src_h), .max_last(CW'(MAX_HEIGHT - 1)), .lo(ylo_w), .hi(yhi_w),
    .frac(fy));
  assign x0 = XW'(xlo_w);
  assign x1 = XW'(xhi_w);
  assign y0 = YW'(ylo_w);
  assign y1 = YW'(yhi_w);

  // stage 3: bank read; bank index = {row parity, col parity}
  logic [BAW-1:0] raddr [4];
  logic [HXW-1:0] bx [2];
  logic [HYW-1:0] by [2];
  always_comb begin
    // even column of pair: x0 if x0 even else x1
    bx[0] = x0[0] ? x1[XW-1:1] : x0[XW-1:1];
    bx[1] = x0[0] ? x0[XW-1:1] : x1[XW-1:1];
    by[0] = y0[0] ? y1[YW-1:1] : y0[YW-1:1];
    by[1] = y0[0] ? y0[YW-1:1] : y1[YW-1:1];
    for (int k = 0; k < 4; k++) raddr[k] = {by[k/2], bx[k%2]};
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic wsel;
    assign wsel = wv_r && en && (wy_r[0] == 1'(k/2)) && (wx_r[0] == 1'(k%2));
    bis_ram #(.DEPTH(BANK_DEPTH), .AW(BAW), .DW(24)) u_ram (
      .clk, .we(wsel), .waddr({wy_r[YW-1:1], wx_r[XW-1:1]}), .wdata(wpix_r),
      .re(en), .raddr(raddr[k]), .rdata(bank_q[k]));
  end

  // writes hit stage 1 and reads are issued at stage 2, so ordering holds
  always_ff @(posedge clk) begin
    if (en) begin
      sel_r <= {y1[0], y0[0], x1[0], x0[0]};
      fx_r  <= fx;
      fy_r  <= fy;
    end
  end
  assign fx_q = fx_r;
  assign fy_q = fy_r;

  assign n00 = bank_q[{sel_r[2], sel_r[0]}];
  assign n01 = bank_q[{sel_r[2], sel_r[1]}];
  assign n10 = bank_q[{sel_r[3], sel_r[0]}];
  assign n11 = bank_q[{sel_r[3], sel_r[1]}];

  // stages 4-5
  bis_blend u_r (.clk, .en, .p00(n00.r), .p01(n01.r), .p10(n10.r), .p11(n11.r),
    .fx(fx_q), .fy(fy_q), .res(r_c));
  bis_blend u_g (.clk, .en, .p00(n00.g), .p01(n01.g), .p10(n10.g), .p11(n11.g),
    .fx(fx_q), .fy(fy_q), .res(g_c));
  bis_blend u_b (.clk, .en, .p00(n00.b), .p01(n01.b), .p10(n10.b), .p11(n11.b),
    .fx(fx_q), .fy(fy_q), .res(b_c));

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_out_of_range <= oor_r[4];
      out_red_out   <= oor_r[4] ? 8'd0 : r_c;
      out_green_out <= oor_r[4] ? 8'd0 : g_c;
      out_blue_out  <= oor_r[4] ? 8'd0 : b_c;
    end
  end
  assign out_valid = rv_r[5];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_red_out == 8'd0 && out_blue_out == 8'd0)
    else $error("out-of-range result not zero");
endmodule
`default_nettype wire
